// ===== design/kfcv_pkg.sv =====
// Shared types, constants and fixed-point helpers for the constant-velocity Kalman filter core.
package kfcv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int STATE_DIM = 4;
    localparam int FX_W      = 32;
    localparam int NOISE_W   = 25;
    localparam int DATA_W    = STATE_DIM * FX_W;
    localparam int CFG_IDX_W = 2;

    // Wide enough for a sum of four rounded products and for a signed quotient.
    localparam int ACC_W  = ((2 * FX_W + 2 - FRAC_BITS) > (FX_W + 2 + FRAC_BITS)) ?
                            (2 * FX_W + 2 - FRAC_BITS) : (FX_W + 2 + FRAC_BITS);
    localparam int DIV_W  = FX_W + FRAC_BITS;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    localparam int MEM_DEPTH = 96;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    typedef logic signed [FX_W-1:0]  t_fx;
    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [ADDR_W-1:0]       t_addr;

    localparam t_fx FX_ONE = t_fx'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [2*FX_W-1:0] RND_HALF = (2*FX_W)'(64'sd1 <<< (FRAC_BITS - 1));
    localparam t_acc SAT_HI = {{(ACC_W-FX_W+1){1'b0}}, {(FX_W-1){1'b1}}};
    localparam t_acc SAT_LO = {{(ACC_W-FX_W+1){1'b1}}, {(FX_W-1){1'b0}}};

    localparam logic [NOISE_W-1:0] PROC_NOISE_RST = NOISE_W'(66);
    localparam logic [NOISE_W-1:0] MEAS_NOISE_RST = NOISE_W'(6554);

    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = CFG_IDX_W'(1);

    // Memory regions of sixteen words each.
    localparam logic [2:0] RG_P   = 3'd0;
    localparam logic [2:0] RG_PP  = 3'd1;
    localparam logic [2:0] RG_A   = 3'd2;
    localparam logic [2:0] RG_INV = 3'd3;
    localparam logic [2:0] RG_K   = 3'd4;
    localparam logic [2:0] RG_X   = 3'd5;

    // Sub-blocks of the vector region.
    localparam logic [1:0] XV_EST   = 2'd0;
    localparam logic [1:0] XV_PRED  = 2'd1;
    localparam logic [1:0] XV_INNOV = 2'd2;

    function automatic t_acc sx_fx(input t_fx v);
        sx_fx = {{(ACC_W-FX_W){v[FX_W-1]}}, v};
    endfunction

    function automatic t_fx sat_fx(input t_acc v);
        t_fx r;
        if (v > SAT_HI) begin
            r = SAT_HI[FX_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[FX_W-1:0];
        end else begin
            r = v[FX_W-1:0];
        end
        sat_fx = r;
    endfunction

    // Round half up: floor((p + half) / 2^FRAC_BITS).
    function automatic t_acc rnd_prod(input logic signed [2*FX_W-1:0] p);
        logic signed [2*FX_W-1:0] s;
        s = (p + RND_HALF) >>> FRAC_BITS;
        rnd_prod = s[ACC_W-1:0];
    endfunction

endpackage

// ===== design/kalman_filter_4state_cv_core.sv =====
// Four-state constant-velocity Kalman filter: sequencer, state memory, shared multiplier, divider.
// Processing of a measurement is dominated by the 32 pivot-row divisions of the 4x4 inversion
// (one quotient bit per cycle, 48 bits each).
// Throughput: one measurement at a time; the next is taken once the estimate is staged for output.
// Reset: synchronous, active low; afterwards an init pass writes the identity covariance and a
// zero state into memory, and no input is accepted until it ends.
module kalman_filter_4state_cv_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // meas_pos_x [31:0], meas_pos_y [63:32], meas_vel_x [95:64], meas_vel_y [127:96]
    input  logic [kfcv_pkg::DATA_W-1:0]    i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // est_pos_x [31:0], est_pos_y [63:32], est_vel_x [95:64], est_vel_y [127:96]
    output logic [kfcv_pkg::DATA_W-1:0]    o_m_axis_tdata,
    // singular_flag [0]
    output logic                           o_m_axis_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kfcv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kfcv_pkg::NOISE_W-1:0]   i_cfg_data
);
    import kfcv_pkg::*;

    localparam logic [3:0] ST_INIT = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_EW   = 4'd2;
    localparam logic [3:0] ST_SRCH = 4'd3;
    localparam logic [3:0] ST_SWAP = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_ELIM = 4'd6;
    localparam logic [3:0] ST_DOT  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    localparam logic [3:0] PS_XP    = 4'd0;
    localparam logic [3:0] PS_INNOV = 4'd1;
    localparam logic [3:0] PS_AP    = 4'd2;
    localparam logic [3:0] PS_PP    = 4'd3;
    localparam logic [3:0] PS_S     = 4'd4;
    localparam logic [3:0] PS_ID    = 4'd5;
    localparam logic [3:0] PS_ZK    = 4'd6;
    localparam logic [3:0] PS_K     = 4'd7;
    localparam logic [3:0] PS_X     = 4'd8;
    localparam logic [3:0] PS_PN    = 4'd9;

    localparam logic [4:0] INIT_LAST = 5'd19;
    localparam logic [4:0] ELIM_LAST = 5'd23;

    logic [3:0]            r_state;
    logic [3:0]            r_pass;
    logic [4:0]            r_e;
    logic [2:0]            r_ph;
    logic [1:0]            r_c;
    logic                  r_sing;
    logic [NOISE_W-1:0]    r_qn;
    logic [NOISE_W-1:0]    r_rn;
    logic                  r_m_valid;
    logic [DATA_W-1:0]     r_m_data;
    logic                  r_m_user;

    t_fx                   r_z   [STATE_DIM];
    t_fx                   r_est [STATE_DIM];
    t_fx                   r_hold;
    t_fx                   r_f;
    t_fx                   r_piv;
    logic [FX_W-1:0]       r_best;
    logic [1:0]            r_row;
    logic signed [2*FX_W-1:0] r_prod;
    t_acc                  r_acc;
    logic [FX_W-1:0]       r_rem;
    logic [DIV_W-1:0]      r_quo;
    logic [DCNT_W-1:0]     r_dcnt;
    logic                  r_dneg;

    logic [FX_W-1:0]       mem [MEM_DEPTH];
    t_fx                   rd_a;
    t_fx                   rd_b;
    t_addr                 ra;
    t_addr                 rb;
    logic                  we;
    t_addr                 wa;
    t_fx                   wd;

    logic [1:0]            e_hi;
    logic [1:0]            e_lo;
    logic                  e_diag;
    logic [2:0]            sw_base;
    logic [1:0]            el_i;
    logic [1:0]            dot_i;
    logic [1:0]            k_dat;
    logic [4:0]            ew_last;
    logic [4:0]            dot_last;
    t_fx                   ew_val;
    t_fx                   ew_tmp;
    t_addr                 ew_wa;
    t_fx                   dot_opa;
    t_fx                   acc_sat;
    t_fx                   dot_val;
    t_addr                 dot_wa;
    t_fx                   mul_a;
    t_fx                   mul_b;
    logic signed [2*FX_W-1:0] mul_p;
    logic [FX_W-1:0]       srch_mag;
    logic [FX_W-1:0]       div_abs_a;
    logic [FX_W-1:0]       div_d;
    logic [DIV_W-1:0]      div_dividend;
    logic [FX_W:0]         rem_sh;
    logic                  rem_ge;
    logic [FX_W:0]         rem_sub;
    t_acc                  q_ext;
    t_fx                   div_val;
    t_fx                   elim_val;
    logic                  out_free;

    assign e_hi     = r_e[3:2];
    assign e_lo     = r_e[1:0];
    assign e_diag   = (e_hi == e_lo);
    assign sw_base  = r_e[2] ? RG_INV : RG_A;
    assign el_i     = (r_e[4:3] < r_c) ? r_e[4:3] : (r_e[4:3] + 2'd1);
    assign dot_i    = (r_pass == PS_X) ? e_lo : e_hi;
    assign k_dat    = r_ph[1:0] - 2'd1;
    assign ew_last  = (r_pass == PS_XP || r_pass == PS_INNOV) ? 5'd3 : 5'd15;
    assign dot_last = (r_pass == PS_X) ? 5'd3 : 5'd15;
    assign out_free = !r_m_valid || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;
    assign o_cfg_ready     = 1'b1;

    // Element-wise passes: prediction, innovation, F*P, predicted covariance, S, the identity seed and the zero gain.
    always_comb begin
        ew_tmp = sat_fx(sx_fx(rd_a) + ((e_lo < 2'd2) ? sx_fx(rd_b) : '0));
        ew_val = '0;
        ew_wa  = {RG_K, r_e[3:0]};
        case (r_pass)
            PS_XP: begin
                ew_val = sat_fx(sx_fx(rd_a) + ((e_lo < 2'd2) ? sx_fx(rd_b) : '0));
                ew_wa  = {RG_X, XV_PRED, e_lo};
            end
            PS_INNOV: begin
                ew_val = sat_fx(sx_fx(r_z[e_lo]) - sx_fx(rd_a));
                ew_wa  = {RG_X, XV_INNOV, e_lo};
            end
            PS_AP: begin
                ew_val = sat_fx(sx_fx(rd_a) + ((e_hi < 2'd2) ? sx_fx(rd_b) : '0));
                ew_wa  = {RG_A, r_e[3:0]};
            end
            PS_PP: begin
                ew_val = e_diag ? sat_fx(sx_fx(ew_tmp) + t_acc'({1'b0, r_qn})) : ew_tmp;
                ew_wa  = {RG_PP, r_e[3:0]};
            end
            PS_S: begin
                ew_val = e_diag ? sat_fx(sx_fx(rd_a) + t_acc'({1'b0, r_rn})) : rd_a;
                ew_wa  = {RG_A, r_e[3:0]};
            end
            PS_ID: begin
                ew_val = e_diag ? FX_ONE : '0;
                ew_wa  = {RG_INV, r_e[3:0]};
            end
            default: begin
                ew_val = '0;
                ew_wa  = {RG_K, r_e[3:0]};
            end
        endcase
    end

    // Dot products, the pivot magnitude, the divider datapath, the elimination update and the shared multiplier.
    always_comb begin
        dot_opa = (r_pass == PS_PN) ?
                  sat_fx(((dot_i == k_dat) ? sx_fx(FX_ONE) : '0) - sx_fx(rd_a)) : rd_a;
        acc_sat = sat_fx(r_acc);
        dot_val = (r_pass == PS_X) ? sat_fx(sx_fx(r_hold) + sx_fx(acc_sat)) : acc_sat;
        case (r_pass)
            PS_K:    dot_wa = {RG_K, r_e[3:0]};
            PS_X:    dot_wa = {RG_X, XV_EST, e_lo};
            default: dot_wa = {RG_P, r_e[3:0]};
        endcase

        mul_a = (r_state == ST_ELIM) ? r_f : dot_opa;
        mul_b = rd_b;
        mul_p = mul_a * mul_b;

        srch_mag     = rd_a[FX_W-1] ? FX_W'(-rd_a) : rd_a;
        div_abs_a    = rd_a[FX_W-1] ? FX_W'(-rd_a) : rd_a;
        div_d        = r_piv[FX_W-1] ? FX_W'(-r_piv) : r_piv;
        div_dividend = {div_abs_a, {FRAC_BITS{1'b0}}} + DIV_W'(div_d >> 1);
        rem_sh       = {r_rem, r_quo[DIV_W-1]};
        rem_ge       = (rem_sh >= {1'b0, div_d});
        rem_sub      = rem_ge ? (rem_sh - {1'b0, div_d}) : rem_sh;
        q_ext        = {{(ACC_W-DIV_W){1'b0}}, r_quo};
        div_val      = sat_fx(r_dneg ? -q_ext : q_ext);

        elim_val = sat_fx(sx_fx(r_hold) - rnd_prod(r_prod));
    end

    // Memory read and write addresses for each state.
    always_comb begin
        ra = '0;
        rb = '0;
        we = 1'b0;
        wa = '0;
        wd = '0;
        unique case (r_state)
            ST_INIT: begin
                we = 1'b1;
                wa = r_e[4] ? {RG_X, XV_EST, r_e[1:0]} : {RG_P, r_e[3:0]};
                wd = (!r_e[4] && e_diag) ? FX_ONE : '0;
            end
            ST_EW: begin
                case (r_pass)
                    PS_XP: begin
                        ra = {RG_X, XV_EST, e_lo};
                        rb = {RG_X, XV_EST, e_lo + 2'd2};
                    end
                    PS_INNOV: ra = {RG_X, XV_PRED, e_lo};
                    PS_AP: begin
                        ra = {RG_P, r_e[3:0]};
                        rb = {RG_P, r_e[3:0] + 4'd8};
                    end
                    PS_PP: begin
                        ra = {RG_A, r_e[3:0]};
                        rb = {RG_A, e_hi, e_lo + 2'd2};
                    end
                    PS_S:    ra = {RG_PP, r_e[3:0]};
                    default: ra = '0;
                endcase
                we = (r_ph == 3'd1);
                wa = ew_wa;
                wd = ew_val;
            end
            ST_SRCH: ra = {RG_A, e_lo, r_c};
            ST_SWAP: begin
                ra = {sw_base, r_row, e_lo};
                rb = {sw_base, r_c, e_lo};
                we = (r_ph == 3'd1) || (r_ph == 3'd2);
                wa = (r_ph == 3'd1) ? {sw_base, r_c, e_lo} : {sw_base, r_row, e_lo};
                wd = (r_ph == 3'd1) ? rd_a : r_hold;
            end
            ST_DIV: begin
                ra = {sw_base, r_c, e_lo};
                we = (r_ph == 3'd3);
                wa = {sw_base, r_c, e_lo};
                wd = div_val;
            end
            ST_ELIM: begin
                ra = (r_ph == 3'd0) ? {RG_A, el_i, r_c} : {sw_base, el_i, e_lo};
                rb = {sw_base, r_c, e_lo};
                we = (r_ph == 3'd4);
                wa = {sw_base, el_i, e_lo};
                wd = elim_val;
            end
            ST_DOT: begin
                case (r_pass)
                    PS_K: begin
                        ra = {RG_PP, dot_i, r_ph[1:0]};
                        rb = {RG_INV, r_ph[1:0], e_lo};
                    end
                    PS_X: begin
                        ra = (r_ph == 3'd4) ? {RG_X, XV_PRED, dot_i} : {RG_K, dot_i, r_ph[1:0]};
                        rb = {RG_X, XV_INNOV, r_ph[1:0]};
                    end
                    default: begin
                        ra = {RG_K, dot_i, r_ph[1:0]};
                        rb = {RG_PP, r_ph[1:0], e_lo};
                    end
                endcase
                we = (r_ph == 3'd6);
                wa = dot_wa;
                wd = dot_val;
            end
            default: begin
                ra = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_a <= mem[ra];
        rd_b <= mem[rb];
    end

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_pass    <= PS_XP;
            r_e       <= '0;
            r_ph      <= '0;
            r_c       <= '0;
            r_sing    <= 1'b0;
            r_qn      <= PROC_NOISE_RST;
            r_rn      <= MEAS_NOISE_RST;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_PROC_NOISE) begin
                    r_qn <= i_cfg_data;
                end else if (i_cfg_index == CFG_MEAS_NOISE) begin
                    r_rn <= i_cfg_data;
                end
            end

            if (r_state == ST_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                ST_INIT: begin
                    if (r_e == INIT_LAST) begin
                        r_e     <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_e <= r_e + 5'd1;
                    end
                end
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_sing  <= 1'b0;
                        r_pass  <= PS_XP;
                        r_e     <= '0;
                        r_ph    <= '0;
                        r_state <= ST_EW;
                    end
                end
                ST_EW: begin
                    if (r_ph == 3'd0) begin
                        r_ph <= 3'd1;
                    end else begin
                        r_ph <= 3'd0;
                        if (r_e == ew_last) begin
                            r_e <= '0;
                            case (r_pass)
                                PS_XP:    r_pass <= PS_INNOV;
                                PS_INNOV: r_pass <= PS_AP;
                                PS_AP:    r_pass <= PS_PP;
                                PS_PP:    r_pass <= PS_S;
                                PS_S:     r_pass <= PS_ID;
                                PS_ID: begin
                                    r_c     <= '0;
                                    r_state <= ST_SRCH;
                                end
                                default: begin
                                    r_pass  <= PS_X;
                                    r_state <= ST_DOT;
                                end
                            endcase
                        end else begin
                            r_e <= r_e + 5'd1;
                        end
                    end
                end
                ST_SRCH: begin
                    if (r_ph == 3'd0) begin
                        r_ph <= 3'd1;
                    end else if (r_ph == 3'd1) begin
                        if (e_lo == 2'd3) begin
                            r_ph <= 3'd2;
                        end else begin
                            r_e  <= r_e + 5'd1;
                            r_ph <= 3'd0;
                        end
                    end else begin
                        r_e  <= '0;
                        r_ph <= '0;
                        if (r_best == '0) begin
                            // No usable pivot: the gain is forced to zero.
                            r_sing  <= 1'b1;
                            r_pass  <= PS_ZK;
                            r_state <= ST_EW;
                        end else if (r_row != r_c) begin
                            r_state <= ST_SWAP;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_SWAP: begin
                    if (r_ph == 3'd2) begin
                        r_ph <= '0;
                        if (r_e == 5'd7) begin
                            r_e     <= '0;
                            r_state <= ST_DIV;
                        end else begin
                            r_e <= r_e + 5'd1;
                        end
                    end else begin
                        r_ph <= r_ph + 3'd1;
                    end
                end
                ST_DIV: begin
                    if (r_ph == 3'd0 || r_ph == 3'd1) begin
                        r_ph <= r_ph + 3'd1;
                    end else if (r_ph == 3'd2) begin
                        if (r_dcnt == '0) begin
                            r_ph <= 3'd3;
                        end
                    end else begin
                        r_ph <= '0;
                        if (r_e == 5'd7) begin
                            r_e     <= '0;
                            r_state <= ST_ELIM;
                        end else begin
                            r_e <= r_e + 5'd1;
                        end
                    end
                end
                ST_ELIM: begin
                    if (r_ph != 3'd4) begin
                        r_ph <= r_ph + 3'd1;
                    end else if (r_e == ELIM_LAST) begin
                        r_ph <= '0;
                        if (r_c == 2'd3) begin
                            r_e     <= '0;
                            r_pass  <= PS_K;
                            r_state <= ST_DOT;
                        end else begin
                            r_c     <= r_c + 2'd1;
                            r_e     <= {3'b000, r_c + 2'd1};
                            r_state <= ST_SRCH;
                        end
                    end else begin
                        // A new row starts by fetching its elimination factor.
                        r_ph <= (r_e[2:0] == 3'd7) ? 3'd0 : 3'd2;
                        r_e  <= r_e + 5'd1;
                    end
                end
                ST_DOT: begin
                    if (r_ph != 3'd6) begin
                        r_ph <= r_ph + 3'd1;
                    end else begin
                        r_ph <= '0;
                        if (r_e == dot_last) begin
                            r_e <= '0;
                            case (r_pass)
                                PS_K:    r_pass <= PS_X;
                                PS_X:    r_pass <= PS_PN;
                                default: r_state <= ST_DONE;
                            endcase
                        end else begin
                            r_e <= r_e + 5'd1;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_s_axis_tvalid) begin
            for (int i = 0; i < STATE_DIM; i++) begin
                r_z[i] <= i_s_axis_tdata[i*FX_W +: FX_W];
            end
        end

        if (r_state == ST_SRCH && r_ph == 3'd1) begin
            if (e_lo == r_c || srch_mag > r_best) begin
                r_best <= srch_mag;
                r_row  <= e_lo;
                r_piv  <= rd_a;
            end
        end

        if (r_state == ST_SWAP && r_ph == 3'd1) begin
            r_hold <= rd_b;
        end

        if (r_state == ST_DIV && r_ph == 3'd1) begin
            r_quo  <= div_dividend;
            r_rem  <= '0;
            r_dcnt <= DCNT_W'(DIV_W);
            r_dneg <= rd_a[FX_W-1] ^ r_piv[FX_W-1];
        end else if (r_state == ST_DIV && r_ph == 3'd2 && r_dcnt != '0) begin
            r_quo  <= {r_quo[DIV_W-2:0], rem_ge};
            r_rem  <= rem_sub[FX_W-1:0];
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end

        if (r_state == ST_ELIM) begin
            if (r_ph == 3'd1) begin
                r_f <= rd_a;
            end
            if (r_ph == 3'd3) begin
                r_prod <= mul_p;
                r_hold <= rd_a;
            end
        end

        if (r_state == ST_DOT) begin
            if (r_ph == 3'd0) begin
                r_acc <= '0;
            end else if (r_ph >= 3'd2 && r_ph <= 3'd5) begin
                r_acc <= r_acc + rnd_prod(r_prod);
            end
            if (r_ph >= 3'd1 && r_ph <= 3'd4) begin
                r_prod <= mul_p;
            end
            if (r_ph == 3'd5) begin
                r_hold <= rd_a;
            end
            if (r_ph == 3'd6 && r_pass == PS_X) begin
                r_est[dot_i] <= dot_val;
            end
        end

        if (r_state == ST_DONE && out_free) begin
            for (int i = 0; i < STATE_DIM; i++) begin
                r_m_data[i*FX_W +: FX_W] <= r_est[i];
            end
            r_m_user <= r_sing;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts_predict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state == ST_EW && r_pass == PS_XP))
        else $error("accepted measurement did not start the prediction pass");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (wa < t_addr'(MEM_DEPTH)))
        else $error("memory write outside the mapped regions");

    a_div_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_ph == 3'd3) |-> (r_dcnt == '0))
        else $error("quotient written before the divider finished");

    a_zero_gain_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EW && r_pass == PS_ZK) |-> r_sing)
        else $error("gain cleared without the singular flag");

    a_result_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (r_m_valid && r_state == ST_IDLE))
        else $error("finished estimate was not staged for output");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the four-state constant-velocity Kalman filter core.
module testbench;
    import kfcv_pkg::*;

    localparam int LIMIT_CYCLES = 8000000;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int N_PHASES = 7;
    localparam longint FX_MAX = 64'sd2147483647;
    localparam longint FX_MIN = -64'sd2147483648;

    typedef longint mat_t [STATE_DIM][STATE_DIM];
    typedef struct packed {
        logic [DATA_W-1:0] est;
        logic              singular;
    } est_t;
    typedef struct {
        logic [DATA_W-1:0] meas;
        bit                known;
        est_t              est;
    } meas_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [DATA_W-1:0]     s_data = '0;
    logic                  m_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [NOISE_W-1:0]    cfg_data = '0;
    wire                   s_ready;
    wire                   m_valid;
    wire [DATA_W-1:0]      m_data;
    wire                   m_user;
    wire                   cfg_ready;

    kalman_filter_4state_cv_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Filter state mirrored by the predictor.
    longint state_est [STATE_DIM];
    mat_t   err_cov;
    longint proc_noise;
    longint meas_noise;

    est_t   pending_est[$];
    int     fail_count = 0;
    int     result_count = 0;
    longint cycle_count = 0;

    function automatic longint sat32(longint v);
        if (v > FX_MAX) return FX_MAX;
        if (v < FX_MIN) return FX_MIN;
        return v;
    endfunction

    // Round half up, which is a floor after adding one half.
    function automatic longint fx_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    // Round to nearest, ties away from zero.
    function automatic longint fx_div(longint a, longint b);
        longint n, d, q;
        if (b == 0) return 0;
        n = (a < 0 ? -a : a) <<< FRAC_BITS;
        d = b < 0 ? -b : b;
        q = (n + d / 2) / d;
        return sat32(((a < 0) != (b < 0)) ? -q : q);
    endfunction

    function automatic void mat_mul(input mat_t a, input mat_t b, output mat_t r);
        longint acc;
        for (int i = 0; i < STATE_DIM; i++) begin
            for (int j = 0; j < STATE_DIM; j++) begin
                acc = 0;
                for (int k = 0; k < STATE_DIM; k++) acc += fx_mul(a[i][k], b[k][j]);
                r[i][j] = sat32(acc);
            end
        end
    endfunction

    task automatic reset_filter_model();
        for (int i = 0; i < STATE_DIM; i++) begin
            state_est[i] = 0;
            for (int j = 0; j < STATE_DIM; j++)
                err_cov[i][j] = (i == j) ? longint'(FX_ONE) : 64'sd0;
        end
        proc_noise = longint'(PROC_NOISE_RST);
        meas_noise = longint'(MEAS_NOISE_RST);
    endtask

    task automatic kalman_update(input logic [DATA_W-1:0] meas, output est_t res);
        longint z [STATE_DIM];
        longint xp [STATE_DIM];
        longint innov [STATE_DIM];
        mat_t   ap, pp, s, sinv, gain, ik, pn;
        longint v, best, m, piv, f, t, acc;
        int     r;
        bit     singular;
        singular = 0;
        for (int i = 0; i < STATE_DIM; i++) begin
            z[i] = longint'($signed(meas[i*FX_W +: FX_W]));
            v = state_est[i];
            if (i + 2 < STATE_DIM) v += state_est[i+2];
            xp[i] = sat32(v);
        end
        for (int i = 0; i < STATE_DIM; i++) begin
            for (int j = 0; j < STATE_DIM; j++) begin
                v = err_cov[i][j];
                if (i + 2 < STATE_DIM) v += err_cov[i+2][j];
                ap[i][j] = sat32(v);
            end
        end
        for (int i = 0; i < STATE_DIM; i++) begin
            for (int j = 0; j < STATE_DIM; j++) begin
                v = ap[i][j];
                if (j + 2 < STATE_DIM) v += ap[i][j+2];
                v = sat32(v);
                if (i == j) v = sat32(v + proc_noise);
                pp[i][j] = v;
                s[i][j] = (i == j) ? sat32(v + meas_noise) : v;
                sinv[i][j] = (i == j) ? longint'(FX_ONE) : 64'sd0;
            end
        end
        // Gauss-Jordan with partial pivoting; an exactly zero pivot means singular.
        for (int c = 0; c < STATE_DIM && !singular; c++) begin
            r = c;
            best = s[c][c] < 0 ? -s[c][c] : s[c][c];
            for (int i = c + 1; i < STATE_DIM; i++) begin
                m = s[i][c] < 0 ? -s[i][c] : s[i][c];
                if (m > best) begin
                    best = m;
                    r = i;
                end
            end
            if (best == 0) begin
                singular = 1;
            end else begin
                if (r != c) begin
                    for (int j = 0; j < STATE_DIM; j++) begin
                        t = s[r][j]; s[r][j] = s[c][j]; s[c][j] = t;
                        t = sinv[r][j]; sinv[r][j] = sinv[c][j]; sinv[c][j] = t;
                    end
                end
                piv = s[c][c];
                for (int j = 0; j < STATE_DIM; j++) begin
                    s[c][j] = fx_div(s[c][j], piv);
                    sinv[c][j] = fx_div(sinv[c][j], piv);
                end
                for (int i = 0; i < STATE_DIM; i++) begin
                    if (i != c) begin
                        f = s[i][c];
                        for (int j = 0; j < STATE_DIM; j++) begin
                            s[i][j] = sat32(s[i][j] - fx_mul(f, s[c][j]));
                            sinv[i][j] = sat32(sinv[i][j] - fx_mul(f, sinv[c][j]));
                        end
                    end
                end
            end
        end
        if (singular) begin
            for (int i = 0; i < STATE_DIM; i++)
                for (int j = 0; j < STATE_DIM; j++) gain[i][j] = 0;
        end else begin
            mat_mul(pp, sinv, gain);
        end
        for (int i = 0; i < STATE_DIM; i++) innov[i] = sat32(z[i] - xp[i]);
        for (int i = 0; i < STATE_DIM; i++) begin
            acc = 0;
            for (int j = 0; j < STATE_DIM; j++) acc += fx_mul(gain[i][j], innov[j]);
            state_est[i] = sat32(xp[i] + sat32(acc));
            res.est[i*FX_W +: FX_W] = state_est[i][FX_W-1:0];
        end
        for (int i = 0; i < STATE_DIM; i++)
            for (int j = 0; j < STATE_DIM; j++)
                ik[i][j] = sat32(((i == j) ? longint'(FX_ONE) : 64'sd0) - gain[i][j]);
        mat_mul(ik, pp, pn);
        err_cov = pn;
        res.singular = singular;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // Output side: random back-pressure, quiet stretches, and one long hold-off.
    int  hold_cycles = 0;
    bit  long_hold_done = 0;
    bit  steady_ready = 0;
    always @(posedge i_clk) begin
        if (!long_hold_done && result_count == 100) begin
            long_hold_done <= 1;
            hold_cycles <= 3 * 2600;
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) == 0) steady_ready <= ~steady_ready;
            if ($urandom_range(0, 299) == 0) begin
                hold_cycles <= $urandom_range(20, 400);
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady_ready ? 1'b1 : ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        est_t exp_e;
        if (i_rst_n && m_valid && m_ready) begin
            result_count <= result_count + 1;
            if (pending_est.size() == 0) begin
                $display("%0t: unexpected result est=%h singular=%b", $time, m_data, m_user);
                fail_count++;
            end else begin
                exp_e = pending_est.pop_front();
                for (int i = 0; i < STATE_DIM; i++) begin
                    if (m_data[i*FX_W +: FX_W] !== exp_e.est[i*FX_W +: FX_W]) begin
                        $display("%0t: estimate %0d expected %h actual %h", $time, i,
                                 exp_e.est[i*FX_W +: FX_W], m_data[i*FX_W +: FX_W]);
                        fail_count++;
                    end
                end
                if (m_user !== exp_e.singular) begin
                    $display("%0t: singular flag expected %b actual %b", $time,
                             exp_e.singular, m_user);
                    fail_count++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NOISE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_PROC_NOISE) proc_noise = longint'(val);
        else if (idx == CFG_MEAS_NOISE) meas_noise = longint'(val);
        @(posedge i_clk);
    endtask

    task automatic send_meas(input logic [DATA_W-1:0] meas, input bit known, input est_t known_e);
        int   gap;
        est_t e;
        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 2);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= meas;
        do @(posedge i_clk); while (!s_ready);
        kalman_update(meas, e);
        pending_est.push_back(known ? known_e : e);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_est.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic logic [FX_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    meas_row_t directed[] = '{
        '{{4{32'h0000_0000}}, 1'b1, '{'0, 1'b0}},
        '{{4{32'h0001_0000}}, 1'b0, '{'0, 1'b0}},
        '{{4{32'hFFFF_0000}}, 1'b0, '{'0, 1'b0}},
        '{{4{32'h7FFF_FFFF}}, 1'b0, '{'0, 1'b0}},
        '{{4{32'h7FFF_FFFF}}, 1'b0, '{'0, 1'b0}},
        '{{4{32'h8000_0000}}, 1'b0, '{'0, 1'b0}},
        '{{4{32'h8000_0000}}, 1'b0, '{'0, 1'b0}},
        '{{4{32'hAAAA_AAAA}}, 1'b0, '{'0, 1'b0}},
        '{{4{32'h5555_5555}}, 1'b0, '{'0, 1'b0}},
        '{{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, '{'0, 1'b0}},
        '{{32'h0000_0001, 32'hFFFF_FFFF, 32'h0002_8000, 32'hFFFD_8000}, 1'b0, '{'0, 1'b0}},
        '{{4{32'hFFFF_FFFF}}, 1'b0, '{'0, 1'b0}}
    };

    initial begin
        longint pos [2];
        longint vel [2];
        logic [DATA_W-1:0] meas;
        est_t dummy;
        logic [NOISE_W-1:0] q_val, r_val;
        dummy = '0;
        reset_filter_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[n]) send_meas(directed[n].meas, directed[n].known, directed[n].est);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // Noise settings: reset, zero, MSB only, all 25 bits set, q=66 r=1.0, random.
            case (ph)
                0: begin q_val = PROC_NOISE_RST; r_val = MEAS_NOISE_RST; end
                1: begin q_val = '0; r_val = '0; end
                2: begin q_val = 25'h100_0000; r_val = 25'h100_0000; end
                3: begin q_val = 25'h1FF_FFFF; r_val = 25'h1FF_FFFF; end
                4: begin q_val = 25'd66; r_val = 25'd65536; end
                default: begin
                    q_val = NOISE_W'($urandom_range(0, 25'h1FF_FFFF));
                    r_val = NOISE_W'($urandom_range(0, 25'h1FF_FFFF));
                end
            endcase
            if (ph > 0) begin
                write_reg(CFG_PROC_NOISE, q_val);
                write_reg(CFG_MEAS_NOISE, r_val);
            end
            if (ph == 2) write_reg(CFG_IDX_W'(2), NOISE_W'($urandom));
            if (ph == 5) write_reg(CFG_IDX_W'(3), NOISE_W'($urandom));
            for (int i = 0; i < 2; i++) begin
                pos[i] = $signed($urandom_range(0, 32'h00FF_FFFF)) - 64'sh0080_0000;
                vel[i] = $signed($urandom_range(0, 32'h0003_FFFF)) - 64'sh0002_0000;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(0, 9)) inside
                    [0:6]: begin
                        // Target moving at near-constant velocity, measured with noise.
                        for (int i = 0; i < 2; i++) begin
                            vel[i] = sat32(vel[i] + $signed($urandom_range(0, 2047)) - 1024);
                            pos[i] = sat32(pos[i] + vel[i]);
                            meas[i*FX_W +: FX_W] = FX_W'(
                                sat32(pos[i] + $signed($urandom_range(0, 8191)) - 4096));
                            meas[(i+2)*FX_W +: FX_W] = FX_W'(
                                sat32(vel[i] + $signed($urandom_range(0, 4095)) - 2048));
                        end
                    end
                    [7:8]: meas = {$urandom, $urandom, $urandom, $urandom};
                    default: meas = {pick_extreme(), pick_extreme(), pick_extreme(),
                                     pick_extreme()};
                endcase
                send_meas(meas, 1'b0, dummy);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
